/* hdl/lspdq_pkg.sv */
// ----------------------------------------------------------------------------
// lspdq_pkg
// Shared widths, constants, codes and types of the spectral envelope
// delta quantizer.
// ----------------------------------------------------------------------------
package lspdq_pkg;

    // field widths
    localparam int VALUE_W  = 20;
    localparam int CODE_W   = 18;
    localparam int CW_W     = 5;
    localparam int RECON_W  = 25;
    localparam int SUM_W    = 24;
    localparam int LOG2N_W  = 5;

    // format constants
    localparam int ANGLE_FRAC_BITS = 20;
    localparam int AMP_CODE_BITS   = 18;

    // resolution limits
    localparam logic [LOG2N_W-1:0] LOG2N_MIN   = 5'd4;
    localparam logic [LOG2N_W-1:0] LOG2N_MAX   = 5'd18;
    localparam logic [LOG2N_W-1:0] LOG2N_RESET = 5'd10;

    // width of the scaled angle before rounding
    localparam int SHIFT_W = VALUE_W + 18 + 1;

    // divide by five: floor(x / 5) == (x * DIV5_MUL) >> DIV5_SHIFT for x < 2^19
    localparam int DIV5_SHIFT = 21;
    localparam logic [19:0] DIV5_MUL = 20'd419431;

    localparam logic [SUM_W-1:0]   SUM_MAX      = {SUM_W{1'b1}};
    localparam logic [RECON_W-1:0] RECON_MAX    = {RECON_W{1'b1}};
    localparam logic [CODE_W-1:0]  AMP_CODE_MAX = {CODE_W{1'b1}};

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_LOG2_N    = 1'b1;

    // direction and item codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;
    localparam logic FUNC_AMP   = 1'b0;
    localparam logic FUNC_COEF  = 1'b1;

    // configuration seen by the datapath
    typedef struct packed {
        logic               direction;
        logic [LOG2N_W-1:0] log2_n;
    } cfg_t;

endpackage

/* hdl/lspdq_if.sv */
// ----------------------------------------------------------------------------
// lspdq_in_if / lspdq_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface lspdq_in_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [lspdq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface lspdq_out_if;
    logic                           valid;
    logic                           ready;
    logic [lspdq_pkg::CODE_W-1:0]   code;
    logic [lspdq_pkg::CW_W-1:0]     code_width;
    logic [lspdq_pkg::RECON_W-1:0]  recon;
    logic                           is_amplitude;

    modport source (output valid, output code, output code_width, output recon,
                    output is_amplitude, input ready);
    modport sink   (input valid, input code, input code_width, input recon,
                    input is_amplitude, output ready);
endinterface

/* hdl/lspdq_cfg.sv */
// ----------------------------------------------------------------------------
// lspdq_cfg
// APB register file holding the direction and the log2 resolution.
// ----------------------------------------------------------------------------
module lspdq_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lspdq_pkg::PADDR_W-1:0]     paddr,
    input  logic [lspdq_pkg::PDATA_W-1:0]     pwdata,
    output logic [lspdq_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    output lspdq_pkg::cfg_t                   cfg
);

    logic                              direction_reg;
    logic [lspdq_pkg::LOG2N_W-1:0]     log2_n_reg;
    logic                              wr_en;
    logic                              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= lspdq_pkg::DIR_ENCODE;
            log2_n_reg    <= lspdq_pkg::LOG2N_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                lspdq_pkg::REG_DIRECTION: direction_reg <= pwdata[0];
                lspdq_pkg::REG_LOG2_N:    log2_n_reg <= pwdata[lspdq_pkg::LOG2N_W-1:0];
                default:                  direction_reg <= direction_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            lspdq_pkg::REG_DIRECTION: prdata[0] = direction_reg;
            lspdq_pkg::REG_LOG2_N:    prdata[lspdq_pkg::LOG2N_W-1:0] = log2_n_reg;
            default:                  prdata = '0;
        endcase
    end

    assign cfg.direction = direction_reg;
    assign cfg.log2_n    = log2_n_reg;

endmodule

/* hdl/lspdq_core.sv */
// ----------------------------------------------------------------------------
// lspdq_core
// Input register, single-pass quantize/reconstruct logic with the running
// state, and the result register.
// ----------------------------------------------------------------------------
module lspdq_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lspdq_pkg::cfg_t      cfg,
    lspdq_in_if.sink             in_ch,
    lspdq_out_if.source          out_ch
);

    // input stage
    logic                               in_vld_reg;
    logic                               in_func_reg;
    logic [lspdq_pkg::VALUE_W-1:0]      in_value_reg;

    // running state
    logic [lspdq_pkg::SUM_W-1:0]        sum_reg;
    logic [lspdq_pkg::RECON_W-1:0]      prev_reg;

    // result stage
    logic                               out_vld_reg;
    logic [lspdq_pkg::CODE_W-1:0]       code_reg;
    logic [lspdq_pkg::CW_W-1:0]         cw_reg;
    logic [lspdq_pkg::RECON_W-1:0]      recon_reg;
    logic                               amp_reg;

    logic                               fire;

    // datapath signals
    logic [lspdq_pkg::LOG2N_W-1:0]      bits;
    logic [lspdq_pkg::CODE_W:0]         cmask_w;
    logic [lspdq_pkg::CODE_W-1:0]       cmask;
    logic [lspdq_pkg::VALUE_W+2:0]      amp_x5;
    logic [lspdq_pkg::CODE_W-1:0]       amp_code;
    logic [lspdq_pkg::CODE_W:0]         amp_round;
    logic [lspdq_pkg::CODE_W+20:0]      amp_prod;
    logic [lspdq_pkg::RECON_W-1:0]      amp_recon;
    logic [lspdq_pkg::SHIFT_W-1:0]      ang_scaled;
    logic [lspdq_pkg::SHIFT_W-1:0]      ang_units;
    logic [lspdq_pkg::SUM_W-1:0]        ang_t;
    logic [lspdq_pkg::SUM_W-1:0]        ang_diff;
    logic [lspdq_pkg::SUM_W:0]          dec_sum;
    logic [lspdq_pkg::CODE_W-1:0]       coef_code;
    logic [lspdq_pkg::SUM_W-1:0]        sum_next;
    logic [lspdq_pkg::RECON_W-1:0]      twice_sum;
    logic [lspdq_pkg::RECON_W:0]        prev_p1;
    logic [lspdq_pkg::RECON_W:0]        recon_max;
    logic [lspdq_pkg::RECON_W-1:0]      coef_recon;

    // handshake: compute when the result slot is free or being emptied
    assign fire         = in_vld_reg & (~out_vld_reg | out_ch.ready);
    assign in_ch.ready  = ~in_vld_reg | fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_func_reg  <= in_ch.func;
            in_value_reg <= in_ch.value;
        end
    end

    // effective resolution and code mask
    always_comb
    begin
        if (cfg.log2_n < lspdq_pkg::LOG2N_MIN)
            bits = lspdq_pkg::LOG2N_MIN;
        else if (cfg.log2_n > lspdq_pkg::LOG2N_MAX)
            bits = lspdq_pkg::LOG2N_MAX;
        else
            bits = cfg.log2_n;
        cmask_w = ((lspdq_pkg::CODE_W+1)'(1) << bits) - (lspdq_pkg::CODE_W+1)'(1);
        cmask   = cmask_w[lspdq_pkg::CODE_W-1:0];
    end

    // amplitude path: code = sat(value*5) when encoding, the received code when decoding; recon = (code+2)/5
    always_comb
    begin
        amp_x5 = (lspdq_pkg::VALUE_W+3)'(in_value_reg)
               + ((lspdq_pkg::VALUE_W+3)'(in_value_reg) << 2);
        if (cfg.direction == lspdq_pkg::DIR_DECODE)
            amp_code = in_value_reg[lspdq_pkg::CODE_W-1:0];
        else if (amp_x5 > (lspdq_pkg::VALUE_W+3)'(lspdq_pkg::AMP_CODE_MAX))
            amp_code = lspdq_pkg::AMP_CODE_MAX;
        else
            amp_code = amp_x5[lspdq_pkg::CODE_W-1:0];
        amp_round = (lspdq_pkg::CODE_W+1)'(amp_code) + (lspdq_pkg::CODE_W+1)'(2);
        amp_prod  = (lspdq_pkg::CODE_W+21)'(amp_round)
                  * (lspdq_pkg::CODE_W+21)'(lspdq_pkg::DIV5_MUL);
        amp_recon = lspdq_pkg::RECON_W'(amp_prod >> lspdq_pkg::DIV5_SHIFT);
    end

    // coefficient path: delta coding and monotonic reconstruction
    always_comb
    begin
        ang_scaled = (lspdq_pkg::SHIFT_W'(in_value_reg) << bits)
                   + (lspdq_pkg::SHIFT_W'(1) << (lspdq_pkg::ANGLE_FRAC_BITS - 1));
        ang_units  = ang_scaled >> lspdq_pkg::ANGLE_FRAC_BITS;
        if (ang_units > lspdq_pkg::SHIFT_W'(lspdq_pkg::SUM_MAX))
            ang_t = lspdq_pkg::SUM_MAX;
        else
            ang_t = ang_units[lspdq_pkg::SUM_W-1:0];
        ang_diff = ang_t - sum_reg;

        dec_sum = (lspdq_pkg::SUM_W+1)'(sum_reg)
                + (lspdq_pkg::SUM_W+1)'(in_value_reg[lspdq_pkg::CODE_W-1:0] & cmask);

        if (cfg.direction == lspdq_pkg::DIR_ENCODE)
        begin
            coef_code = ang_diff[lspdq_pkg::CODE_W-1:0] & cmask;
            sum_next  = ang_t;
        end
        else
        begin
            coef_code = in_value_reg[lspdq_pkg::CODE_W-1:0] & cmask;
            sum_next  = dec_sum[lspdq_pkg::SUM_W] ? lspdq_pkg::SUM_MAX
                                                  : dec_sum[lspdq_pkg::SUM_W-1:0];
        end

        twice_sum = {sum_next, 1'b0};
        prev_p1   = (lspdq_pkg::RECON_W+1)'(prev_reg) + (lspdq_pkg::RECON_W+1)'(1);
        recon_max = ((lspdq_pkg::RECON_W+1)'(twice_sum) < prev_p1)
                  ? prev_p1 : (lspdq_pkg::RECON_W+1)'(twice_sum);
        coef_recon = recon_max[lspdq_pkg::RECON_W] ? lspdq_pkg::RECON_MAX
                                                   : recon_max[lspdq_pkg::RECON_W-1:0];
    end

    // running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end
        else if (fire)
        begin
            if (in_func_reg == lspdq_pkg::FUNC_AMP)
            begin
                sum_reg  <= '0;
                prev_reg <= '0;
            end
            else
            begin
                sum_reg  <= sum_next;
                prev_reg <= coef_recon;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (in_func_reg == lspdq_pkg::FUNC_AMP)
            begin
                code_reg  <= amp_code;
                cw_reg    <= lspdq_pkg::CW_W'(lspdq_pkg::AMP_CODE_BITS);
                recon_reg <= amp_recon;
                amp_reg   <= 1'b1;
            end
            else
            begin
                code_reg  <= coef_code;
                cw_reg    <= bits;
                recon_reg <= coef_recon;
                amp_reg   <= 1'b0;
            end
        end
    end

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.code         = code_reg;
    assign out_ch.code_width   = cw_reg;
    assign out_ch.recon        = recon_reg;
    assign out_ch.is_amplitude = amp_reg;

    // an amplitude item clears the running state
    a_amp_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_func_reg == lspdq_pkg::FUNC_AMP |=> sum_reg == '0 && prev_reg == '0)
        else $error("amplitude item did not clear running state");

    // reconstruction rises with every coefficient until saturation
    a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_func_reg == lspdq_pkg::FUNC_COEF |=>
            prev_reg > $past(prev_reg) || $past(prev_reg) == lspdq_pkg::RECON_MAX)
        else $error("reconstruction not monotonic");

    // coefficient results are never zero and carry a clamped code width
    a_coef_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !amp_reg |-> recon_reg != '0 &&
            cw_reg >= lspdq_pkg::LOG2N_MIN && cw_reg <= lspdq_pkg::LOG2N_MAX)
        else $error("bad coefficient result");

    // amplitude results use the fixed code width
    a_amp_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && amp_reg |-> cw_reg == lspdq_pkg::CW_W'(lspdq_pkg::AMP_CODE_BITS))
        else $error("bad amplitude code width");

    // a stored item is never lost: without fire the input stage holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !fire |=> in_vld_reg)
        else $error("input item dropped");

endmodule

/* hdl/lsp_delta_quantizer.sv */
// ----------------------------------------------------------------------------
// lsp_delta_quantizer
// Spectral envelope delta quantizer: amplitude and LSP angle coding.
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries items (func, value): func 0 is the amplitude item that
//   starts a frame and clears the running sum, func 1 a coefficient item.
//   out_ch returns one result per item (code, code_width, recon,
//   is_amplitude), in order.
//   configuration goes over the APB port: direction at 0x0, log2_n at 0x4;
//   write only while no item is in flight.
//   an accepted item is held in the input register, then computed and
//   written into the result register once that register is free.
//   throughput: one item per cycle while out_ch is ready; the running sum
//   and last reconstruction are updated in the same pass that fills the
//   result register.
//   when out_ch stalls, the held result and one further item in the input
//   register are kept; in_ch ready drops only when both are full.
//   reset clears both stages, the running state, direction (encode) and
//   sets log2_n to 10.
// ----------------------------------------------------------------------------
module lsp_delta_quantizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lspdq_pkg::PADDR_W-1:0]     paddr,
    input  logic [lspdq_pkg::PDATA_W-1:0]     pwdata,
    output logic [lspdq_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    lspdq_in_if.sink                          in_ch,
    lspdq_out_if.source                       out_ch
);

    lspdq_pkg::cfg_t cfg;

    // register file
    lspdq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // datapath
    lspdq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

/* tb/sv/lsp_delta_quantizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_delta_quantizer_tb
// Self-checking testbench for the spectral envelope delta quantizer. Items go
// in over in_ch with random gaps and results are taken from out_ch with random
// stalls. A local model of the quantizer predicts every result in order, and
// the checker compares each result field by field. The run covers amplitude
// saturation, angle rounding, negative deltas, the monotonic clamp, decode
// sum saturation, out-of-range resolutions, wide received codes and back
// pressure, in both directions and over several register settings.
// ----------------------------------------------------------------------------
module lsp_delta_quantizer_tb;

    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int SETTLE_CYCLES = 3;
    localparam int HOLD_CYCLES   = 40;
    localparam int MAX_REPORTS   = 40;
    localparam int PHASE_ITEMS   = 52;

    typedef struct packed {
        logic [lspdq_pkg::CODE_W-1:0]  code;
        logic [lspdq_pkg::CW_W-1:0]    code_width;
        logic [lspdq_pkg::RECON_W-1:0] recon;
        logic                          is_amplitude;
    } lsp_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [lspdq_pkg::PADDR_W-1:0] paddr;
    logic [lspdq_pkg::PDATA_W-1:0] pwdata;
    logic [lspdq_pkg::PDATA_W-1:0] prdata;
    logic                          pready;

    lspdq_in_if  in_ch();
    lspdq_out_if out_ch();

    // local copy of the quantizer registers and running state
    lspdq_pkg::cfg_t               model_cfg;
    logic [lspdq_pkg::SUM_W-1:0]   angle_sum;
    logic [lspdq_pkg::RECON_W-1:0] last_recon;

    lsp_result_t pending_results[$];
    int          error_count  = 0;
    int          hold_request = 0;
    bit          calm         = 1'b0;

    lsp_delta_quantizer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // resolution as the datapath uses it
    function automatic logic [lspdq_pkg::CW_W-1:0] effective_bits(
        input logic [lspdq_pkg::LOG2N_W-1:0] l2n);
        if (l2n < lspdq_pkg::LOG2N_MIN)
            return lspdq_pkg::LOG2N_MIN;
        if (l2n > lspdq_pkg::LOG2N_MAX)
            return lspdq_pkg::LOG2N_MAX;
        return l2n;
    endfunction

    // expected result of one item, advancing the running state
    function automatic lsp_result_t quantize_item(
        input logic item_func,
        input logic [lspdq_pkg::VALUE_W-1:0] item_value);
        lsp_result_t                  r;
        logic [lspdq_pkg::CW_W-1:0]   bits;
        logic [lspdq_pkg::CODE_W-1:0] cmask;
        logic [63:0]                  wide;
        logic [31:0]                  sum;
        if (item_func == lspdq_pkg::FUNC_AMP)
        begin
            if (model_cfg.direction == lspdq_pkg::DIR_ENCODE)
            begin
                wide = 64'(item_value) * 64'd5;
                r.code = (wide > 64'(lspdq_pkg::AMP_CODE_MAX)) ? lspdq_pkg::AMP_CODE_MAX
                                                              : wide[lspdq_pkg::CODE_W-1:0];
            end
            else
                r.code = item_value[lspdq_pkg::CODE_W-1:0];
            angle_sum      = '0;
            last_recon     = '0;
            r.code_width   = lspdq_pkg::CW_W'(lspdq_pkg::AMP_CODE_BITS);
            r.recon        = lspdq_pkg::RECON_W'((32'(r.code) + 32'd2) / 32'd5);
            r.is_amplitude = 1'b1;
            return r;
        end
        bits  = effective_bits(model_cfg.log2_n);
        cmask = lspdq_pkg::CODE_W'((64'd1 << bits) - 64'd1);
        if (model_cfg.direction == lspdq_pkg::DIR_ENCODE)
        begin
            // round half up to units of pi/n
            wide = ((64'(item_value) << bits) + (64'd1 << (lspdq_pkg::ANGLE_FRAC_BITS - 1)))
                   >> lspdq_pkg::ANGLE_FRAC_BITS;
            if (wide > 64'(lspdq_pkg::SUM_MAX))
                wide = 64'(lspdq_pkg::SUM_MAX);
            r.code    = lspdq_pkg::CODE_W'(wide - 64'(angle_sum)) & cmask;
            angle_sum = wide[lspdq_pkg::SUM_W-1:0];
        end
        else
        begin
            r.code    = item_value[lspdq_pkg::CODE_W-1:0] & cmask;
            sum       = 32'(angle_sum) + 32'(r.code);
            angle_sum = (sum > 32'(lspdq_pkg::SUM_MAX)) ? lspdq_pkg::SUM_MAX
                                                        : sum[lspdq_pkg::SUM_W-1:0];
        end
        // reconstruction must rise by at least one half unit
        wide = 64'(angle_sum) << 1;
        if (wide < 64'(last_recon) + 64'd1)
            wide = 64'(last_recon) + 64'd1;
        if (wide > 64'(lspdq_pkg::RECON_MAX))
            wide = 64'(lspdq_pkg::RECON_MAX);
        r.recon        = wide[lspdq_pkg::RECON_W-1:0];
        last_recon     = r.recon;
        r.code_width   = bits;
        r.is_amplitude = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // one item onto in_ch; predicted once accepted
    task automatic send_item(input logic item_func,
                             input logic [lspdq_pkg::VALUE_W-1:0] item_value);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func  <= item_func;
        in_ch.value <= item_value;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        pending_results.push_back(quantize_item(item_func, item_value));
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle
    task automatic write_register(input logic idx,
                                  input logic [lspdq_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == lspdq_pkg::REG_DIRECTION)
            model_cfg.direction = data[0];
        else
            model_cfg.log2_n = data[lspdq_pkg::LOG2N_W-1:0];
        @(posedge clk);
    endtask

    task automatic configure(input logic dir, input logic [lspdq_pkg::LOG2N_W-1:0] l2n);
        drain();
        write_register(lspdq_pkg::REG_DIRECTION, lspdq_pkg::PDATA_W'(dir));
        write_register(lspdq_pkg::REG_LOG2_N, lspdq_pkg::PDATA_W'(l2n));
    endtask

    // amplitude mix: unsaturated, saturated, around the saturation point, extremes
    function automatic logic [lspdq_pkg::VALUE_W-1:0] random_amplitude();
        case ($urandom_range(0, 3))
            0: return lspdq_pkg::VALUE_W'($urandom_range(0, 52428));
            1: return lspdq_pkg::VALUE_W'($urandom);
            2: return lspdq_pkg::VALUE_W'($urandom_range(52425, 52432));
            default: return $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    // reset values: encode, log2_n 10
    task automatic test_reset_state();
        send_item(lspdq_pkg::FUNC_AMP, '0);
        send_item(lspdq_pkg::FUNC_AMP, '1);
        send_item(lspdq_pkg::FUNC_AMP, lspdq_pkg::VALUE_W'(52429));
        send_item(lspdq_pkg::FUNC_AMP, lspdq_pkg::VALUE_W'(52428));
        send_item(lspdq_pkg::FUNC_COEF, '0);
        // just below and exactly at half a unit
        send_item(lspdq_pkg::FUNC_COEF, lspdq_pkg::VALUE_W'(511));
        send_item(lspdq_pkg::FUNC_COEF, lspdq_pkg::VALUE_W'(512));
        send_item(lspdq_pkg::FUNC_COEF, '1);
        // negative delta, then a drop below the last reconstruction
        send_item(lspdq_pkg::FUNC_COEF, lspdq_pkg::VALUE_W'(1024));
        send_item(lspdq_pkg::FUNC_COEF, '0);
    endtask

    // log2_n outside 4..18 and received codes wider than their width
    task automatic test_resolution_limits();
        configure(lspdq_pkg::DIR_ENCODE, 5'd0);
        send_item(lspdq_pkg::FUNC_AMP, lspdq_pkg::VALUE_W'(1000));
        send_item(lspdq_pkg::FUNC_COEF, '1);
        configure(lspdq_pkg::DIR_ENCODE, 5'd31);
        send_item(lspdq_pkg::FUNC_AMP, lspdq_pkg::VALUE_W'(1000));
        send_item(lspdq_pkg::FUNC_COEF, '1);
        configure(lspdq_pkg::DIR_ENCODE, 5'd3);
        send_item(lspdq_pkg::FUNC_COEF, lspdq_pkg::VALUE_W'(20'h40000));
        configure(lspdq_pkg::DIR_ENCODE, 5'd19);
        send_item(lspdq_pkg::FUNC_COEF, lspdq_pkg::VALUE_W'(20'h80001));
        configure(lspdq_pkg::DIR_DECODE, 5'd5);
        send_item(lspdq_pkg::FUNC_AMP, '1);
        send_item(lspdq_pkg::FUNC_COEF, '1);
        send_item(lspdq_pkg::FUNC_COEF, '0);
        configure(lspdq_pkg::DIR_DECODE, 5'd31);
        send_item(lspdq_pkg::FUNC_COEF, '1);
        send_item(lspdq_pkg::FUNC_AMP, '0);
    endtask

    // long decode frame of near-maximum codes drives both saturations
    task automatic test_decode_saturation();
        configure(lspdq_pkg::DIR_DECODE, lspdq_pkg::LOG2N_MAX);
        send_item(lspdq_pkg::FUNC_AMP, random_amplitude());
        repeat (70)
            send_item(lspdq_pkg::FUNC_COEF,
                      {2'($urandom), 18'($urandom_range(18'h3F000, 18'h3FFFF))});
        repeat (3)
            send_item(lspdq_pkg::FUNC_COEF, {2'($urandom), 18'h0});
    endtask

    // receiver holds off while the sender keeps going, then the sender waits
    task automatic test_back_pressure();
        configure(lspdq_pkg::DIR_ENCODE, 5'd12);
        calm = 1'b1;
        hold_request = HOLD_CYCLES;
        send_item(lspdq_pkg::FUNC_AMP, random_amplitude());
        repeat (29)
            send_item(lspdq_pkg::FUNC_COEF, lspdq_pkg::VALUE_W'($urandom));
        drain();
        calm = 1'b0;
    endtask

    // random frames under one register setting
    task automatic run_random_phase(input logic dir,
                                    input logic [lspdq_pkg::LOG2N_W-1:0] l2n,
                                    input int budget);
        int                            sent;
        int                            len;
        int                            kind;
        int unsigned                   step_max;
        int unsigned                   cmax;
        logic [lspdq_pkg::VALUE_W-1:0] angle;
        logic [lspdq_pkg::VALUE_W-1:0] v;
        configure(dir, l2n);
        calm = ($urandom_range(0, 3) == 0);
        cmax = (32'd1 << effective_bits(l2n)) - 32'd1;
        sent = 0;
        while (sent < budget)
        begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
            kind = $urandom_range(0, 7);
            // now and then a frame comes without its amplitude item
            if ($urandom_range(0, 7) != 0)
            begin
                send_item(lspdq_pkg::FUNC_AMP, random_amplitude());
                sent++;
            end
            angle    = lspdq_pkg::VALUE_W'($urandom_range(0, 20'h3FFF));
            step_max = 32'hFFFFF / (len + 1) * 2;
            for (int i = 0; i < len; i++)
            begin
                if (dir == lspdq_pkg::DIR_DECODE)
                begin
                    if (kind < 3)
                        v = lspdq_pkg::VALUE_W'($urandom_range(0, cmax));
                    else if (kind < 6)
                        v = lspdq_pkg::VALUE_W'($urandom);
                    else
                        v = lspdq_pkg::VALUE_W'($urandom) & ~lspdq_pkg::VALUE_W'(cmax)
                            | lspdq_pkg::VALUE_W'(cmax - $urandom_range(0, 3));
                end
                else
                begin
                    case (kind)
                        // rising angles, the usual shape of a frame
                        0, 1, 2, 3, 4:
                        begin
                            angle = (32'(angle) + $urandom_range(0, step_max) > 32'hFFFFF)
                                    ? '1
                                    : angle + lspdq_pkg::VALUE_W'($urandom_range(0, step_max));
                        end
                        5: angle = lspdq_pkg::VALUE_W'($urandom);
                        // falling angles: negative deltas and clamping
                        6: angle = (angle > lspdq_pkg::VALUE_W'(step_max))
                                   ? angle - lspdq_pkg::VALUE_W'(step_max) : '0;
                        // sub-unit steps: repeated codes and clamping
                        default: angle = angle + lspdq_pkg::VALUE_W'($urandom_range(0,
                                         32'h1 << (20 - effective_bits(l2n))));
                    endcase
                    v = angle;
                end
                send_item(lspdq_pkg::FUNC_COEF, v);
                sent++;
            end
        end
    endtask

    task automatic test_random_frames();
        logic [lspdq_pkg::LOG2N_W-1:0] l2n;
        run_random_phase(lspdq_pkg::DIR_ENCODE, 5'd4, PHASE_ITEMS);
        run_random_phase(lspdq_pkg::DIR_DECODE, 5'd18, PHASE_ITEMS);
        run_random_phase(lspdq_pkg::DIR_ENCODE, 5'd18, PHASE_ITEMS);
        run_random_phase(lspdq_pkg::DIR_DECODE, 5'd4, PHASE_ITEMS);
        run_random_phase(lspdq_pkg::DIR_ENCODE, 5'd0, PHASE_ITEMS);
        run_random_phase(lspdq_pkg::DIR_DECODE, 5'd31, PHASE_ITEMS);
        run_random_phase(lspdq_pkg::DIR_DECODE, lspdq_pkg::LOG2N_RESET, PHASE_ITEMS);
        run_random_phase(lspdq_pkg::DIR_ENCODE, lspdq_pkg::LOG2N_RESET, PHASE_ITEMS);
        repeat (6)
        begin
            l2n = lspdq_pkg::LOG2N_W'($urandom_range(0, 31));
            run_random_phase(1'($urandom_range(0, 1)), l2n, PHASE_ITEMS);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        lsp_result_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no item pending", out_ch.code, 0);
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.code !== want.code)
                    report_mismatch("code", out_ch.code, want.code);
                if (out_ch.code_width !== want.code_width)
                    report_mismatch("code_width", out_ch.code_width, want.code_width);
                if (out_ch.recon !== want.recon)
                    report_mismatch("recon", out_ch.recon, want.recon);
                if (out_ch.is_amplitude !== want.is_amplitude)
                    report_mismatch("is_amplitude", out_ch.is_amplitude, want.is_amplitude);
            end
        end
    end

    // result receiver: random stall per item, or a long hold when asked
    initial
    begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1 || rst_n !== 1'b1);
        end
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL lsp_delta_quantizer");
        $finish;
    end

    // test sequence
    initial
    begin
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_ch.valid <= 1'b0;
        in_ch.func  <= lspdq_pkg::FUNC_AMP;
        in_ch.value <= '0;
        model_cfg.direction = lspdq_pkg::DIR_ENCODE;
        model_cfg.log2_n    = lspdq_pkg::LOG2N_RESET;
        angle_sum  = '0;
        last_recon = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_resolution_limits();
        test_decode_saturation();
        test_back_pressure();
        test_random_frames();

        drain();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("PASS lsp_delta_quantizer");
        else
            $display("FAIL lsp_delta_quantizer");
        $finish;
    end

endmodule

/* files.f */
hdl/lspdq_pkg.sv
hdl/lspdq_if.sv
hdl/lspdq_cfg.sv
hdl/lspdq_core.sv
hdl/lsp_delta_quantizer.sv
tb/sv/lsp_delta_quantizer_tb.sv
